// ----- design/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants for the circular deque with rotate
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // rotate amount width and the bit counter of the remainder unit
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned AMT_CNT_W = $clog2(AMT_W);

  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_ROTATE     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_MOD,
    S_FIX,
    S_ROT_CHK,
    S_ROT_RD,
    S_ROT_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] data_value;
    logic signed [15:0] rotate_amount;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [4:0]         occupancy;
  } cdq_out_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    push_rear;
    logic    push_front;
    logic    pop_front;
    logic    pop_rear;
    logic    pop_capture;
    logic    div_step;
    logic    k_load;
    logic    rot_read;
    logic    rot_write;
    logic    set_status;
    status_e status;
  } cdq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       div_last;
    logic       k_zero;
    logic       k_last;
  } cdq_sts_t;

endpackage

// ----- design/cdq_dpath.sv -----
// ----------------------------------------------------------------------------
// cdq_dpath
// ring storage, pointers, count, remainder unit and result registers
// ----------------------------------------------------------------------------
module cdq_dpath #(
  parameter int unsigned CAPACITY   = cdq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEF_DATA_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdq_pkg::cdq_in_t  cmd_i,
  input  cdq_pkg::cdq_ctl_t ctl_i,
  output cdq_pkg::cdq_sts_t sts_o,
  output cdq_pkg::cdq_out_t res_o
);
  import cdq_pkg::*;

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [2:0]           cmd_q;
  logic [AMT_W-1:0]     amt_q, amt_d;
  logic                 neg_q;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [AMT_CNT_W-1:0] bit_q, bit_d;
  logic [CNT_W-1:0]     k_q, k_d;
  status_e              status_q, status_d;
  logic signed [31:0]   popped_q, popped_d;

  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [CNT_W:0]   rem_shift;
  logic [CNT_W:0]   rem_sub;
  logic [AMT_W-1:0] amt_mag;
  logic signed [DATA_WIDTH-1:0] rd_signed;

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

  assign amt_mag   = cmd_i.rotate_amount[AMT_W-1] ? AMT_W'(-cmd_i.rotate_amount)
                                                  : AMT_W'(cmd_i.rotate_amount);
  assign rem_shift = {rem_q, amt_q[AMT_W-1]};
  assign rem_sub   = rem_shift - {1'b0, count_q};
  assign rd_signed = rd_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    amt_d    = amt_q;
    rem_d    = rem_q;
    bit_d    = bit_q;
    k_d      = k_q;
    status_d = status_q;
    popped_d = popped_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    wr_data  = data_q;
    if (ctl_i.load) begin
      amt_d    = amt_mag;
      rem_d    = '0;
      bit_d    = AMT_CNT_W'(AMT_W - 1);
      status_d = ST_DONE;
      popped_d = '0;
    end else if (ctl_i.push_rear) begin
      wr_en   = 1'b1;
      wr_addr = tail_q;
      tail_d  = tail_inc;
      count_d = count_q + 1'b1;
    end else if (ctl_i.push_front) begin
      wr_en   = 1'b1;
      wr_addr = head_dec;
      head_d  = head_dec;
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop_front) begin
      rd_en   = 1'b1;
      rd_addr = head_q;
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end else if (ctl_i.pop_rear) begin
      rd_en   = 1'b1;
      rd_addr = tail_dec;
      tail_d  = tail_dec;
      count_d = count_q - 1'b1;
    end else if (ctl_i.pop_capture) begin
      popped_d = 32'(rd_signed);
    end else if (ctl_i.div_step) begin
      rem_d = rem_sub[CNT_W] ? rem_shift[CNT_W-1:0] : rem_sub[CNT_W-1:0];
      amt_d = amt_q << 1;
      bit_d = bit_q - 1'b1;
    end else if (ctl_i.k_load) begin
      k_d = (neg_q && (rem_q != '0)) ? count_q - rem_q : rem_q;
    end else if (ctl_i.rot_read) begin
      rd_en   = 1'b1;
      rd_addr = tail_dec;
      tail_d  = tail_dec;
    end else if (ctl_i.rot_write) begin
      wr_en   = 1'b1;
      wr_addr = head_dec;
      wr_data = rd_q;
      head_d  = head_dec;
      k_d     = k_q - 1'b1;
    end else if (ctl_i.set_status) begin
      status_d = ctl_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= DATA_WIDTH'(cmd_i.data_value);
      neg_q  <= cmd_i.rotate_amount[AMT_W-1];
    end
    amt_q    <= amt_d;
    rem_q    <= rem_d;
    bit_q    <= bit_d;
    k_q      <= k_d;
    popped_q <= popped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      cmd_q    <= '0;
      status_q <= ST_DONE;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (ctl_i.load) begin
        cmd_q <= cmd_i.command;
      end
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.full     = (count_q == FULL_CNT);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.div_last = (bit_q == '0);
  assign sts_o.k_zero   = (k_q == '0);
  assign sts_o.k_last   = (k_q == CNT_W'(1));

  assign res_o.status       = status_q;
  assign res_o.popped_value = popped_q;
  assign res_o.occupancy    = 5'(count_q);

endmodule

// ----- design/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// command sequencer for the circular deque with rotate
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  cdq_pkg::cdq_sts_t sts_i,
  output cdq_pkg::cdq_ctl_t ctl_o,
  output logic              busy_o,
  output logic              done_o
);
  import cdq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_e'(sts_i.cmd))
          CMD_POP_FRONT, CMD_POP_REAR: begin
            state_d = sts_i.empty ? S_RESP : S_POP_WAIT;
          end
          CMD_ROTATE: begin
            state_d = sts_i.empty ? S_RESP : S_MOD;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_POP_WAIT: state_d = S_RESP;
      S_MOD: begin
        if (sts_i.div_last) begin
          state_d = S_FIX;
        end
      end
      S_FIX:     state_d = S_ROT_CHK;
      S_ROT_CHK: state_d = sts_i.k_zero ? S_RESP : S_ROT_RD;
      S_ROT_RD:  state_d = S_ROT_WR;
      S_ROT_WR:  state_d = sts_i.k_last ? S_RESP : S_ROT_RD;
      S_RESP:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    ctl_o.status = ST_DONE;
    busy_o = (state_q != S_IDLE);
    done_o = (state_q == S_RESP);
    case (state_q)
      S_IDLE: begin
        ctl_o.load = start_i;
      end
      S_EXEC: begin
        case (cmd_e'(sts_i.cmd))
          CMD_PUSH_REAR: begin
            ctl_o.push_rear  = !sts_i.full;
            ctl_o.set_status = sts_i.full;
            ctl_o.status     = ST_FULL;
          end
          CMD_PUSH_FRONT: begin
            ctl_o.push_front = !sts_i.full;
            ctl_o.set_status = sts_i.full;
            ctl_o.status     = ST_FULL;
          end
          CMD_POP_FRONT: begin
            ctl_o.pop_front  = !sts_i.empty;
            ctl_o.set_status = sts_i.empty;
            ctl_o.status     = ST_EMPTY;
          end
          CMD_POP_REAR: begin
            ctl_o.pop_rear   = !sts_i.empty;
            ctl_o.set_status = sts_i.empty;
            ctl_o.status     = ST_EMPTY;
          end
          CMD_ROTATE: begin
            ctl_o.set_status = sts_i.empty;
            ctl_o.status     = ST_EMPTY;
          end
          default: begin
            ctl_o.set_status = 1'b0;
          end
        endcase
      end
      S_POP_WAIT: ctl_o.pop_capture = 1'b1;
      S_MOD:      ctl_o.div_step    = 1'b1;
      S_FIX:      ctl_o.k_load      = 1'b1;
      S_ROT_RD:   ctl_o.rot_read    = 1'b1;
      S_ROT_WR:   ctl_o.rot_write   = 1'b1;
      default: begin
        ctl_o.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/circular_deque_with_rotate.sv -----
// ----------------------------------------------------------------------------
// circular_deque_with_rotate
// fixed-capacity double-ended queue of signed words with push, pop and rotate
// ----------------------------------------------------------------------------
//  channel  | ports                  | transfer
//  ---------+------------------------+----------------------------------
//  command  | start, busy, cmd_i     | edge with start high, busy low
//  result   | done_o, res_o          | edge ending the cycle done_o is high
//
//  after accept, push and the empty or full cases pass EXEC and then give the
//  result strobe in RESP; pops add POP_WAIT (one registered read of the ring memory)
//  rotate runs 16 remainder steps, then moves k words, each with a memory
//  read and a memory write, k = amount mod count
//  after reset the deque is empty; busy stays high until the result cycle
//  ends, and the result cannot be stalled
// ----------------------------------------------------------------------------
module circular_deque_with_rotate #(
  parameter int unsigned CAPACITY   = cdq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = cdq_pkg::DEF_DATA_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_in_t  cmd_i,
  output logic              done_o,
  output cdq_pkg::cdq_out_t res_o
);
  import cdq_pkg::*;

  cdq_ctl_t ctl;
  cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  cdq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (res_o)
  );

endmodule

// ----- verif/tb_circular_deque_with_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_with_rotate
// The testbench runs command transfers into the deque and checks every result
// strobe against a behavioral deque that it keeps itself. It starts with a
// directed sequence: empty and full cases, extreme words and rotate amounts,
// and unused command codes. A long random run follows, made of fill, drain and
// mixed segments, with random gaps between transfers.
// ----------------------------------------------------------------------------
module tb_circular_deque_with_rotate;
  import cdq_pkg::*;

  localparam int          RANDOM_ITEMS     = 1650;
  localparam int          DRAIN_CYCLES     = 80;
  localparam int          TIMEOUT_NS       = 5_000_000;
  localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
  localparam int          MODE_FILL        = 0;
  localparam int          MODE_DRAIN       = 1;
  localparam int          MODE_MIXED       = 2;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  cdq_in_t  cmd_i  = '0;
  logic     done_o;
  cdq_out_t res_o;

  cdq_in_t            pending_cmds[$];
  cdq_out_t           expected_results[$];
  logic signed [31:0] deque_words[$];

  int total_items    = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int full_count     = 0;
  int empty_count    = 0;
  int moved_words    = 0;
  int idle_left      = 0;
  int no_idle_run    = 0;

  circular_deque_with_rotate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic cdq_out_t apply_command(cdq_in_t c);
    cdq_out_t           r;
    int                 cnt;
    int                 amt;
    int                 k;
    logic signed [31:0] w;
    r        = '0;
    r.status = ST_DONE;
    cnt      = deque_words.size();
    amt      = c.rotate_amount;
    case (c.command)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (cnt >= int'(DEF_CAPACITY)) begin
          r.status = ST_FULL;
          full_count++;
        end else if (c.command == CMD_PUSH_REAR) begin
          deque_words.push_back(c.data_value);
        end else begin
          deque_words.push_front(c.data_value);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
          empty_count++;
        end else if (c.command == CMD_POP_FRONT) begin
          r.popped_value = deque_words.pop_front();
        end else begin
          r.popped_value = deque_words.pop_back();
        end
      end
      CMD_ROTATE: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
          empty_count++;
        end else begin
          k = ((amt % cnt) + cnt) % cnt;
          moved_words += k;
          repeat (k) begin
            w = deque_words.pop_back();
            deque_words.push_front(w);
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = 5'(deque_words.size());
    return r;
  endfunction

  function automatic cdq_in_t make_cmd(logic [2:0] op, logic [31:0] word, logic [15:0] amt);
    cdq_in_t c;
    c.command       = op;
    c.data_value    = word;
    c.rotate_amount = amt;
    return c;
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h7fff_ffff;
    if (r < 6) return 32'h8000_0000;
    if (r < 8) return 32'h0;
    if (r < 10) return 32'hffff_ffff;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 40));
    if (r < 60) return 16'(-$urandom_range(1, 40));
    if (r < 90) return 16'($urandom);
    if (r < 94) return 16'h7fff;
    if (r < 98) return 16'h8000;
    return 16'h0;
  endfunction

  function automatic cdq_in_t random_cmd(int mode);
    int         r;
    int         push_w;
    int         pop_w;
    logic [2:0] op;
    case (mode)
      MODE_FILL: begin
        push_w = 70;
        pop_w  = 10;
      end
      MODE_DRAIN: begin
        push_w = 15;
        pop_w  = 65;
      end
      default: begin
        push_w = 38;
        pop_w  = 37;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    end else if (r < push_w + pop_w) begin
      op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
    end else if (r < 97) begin
      op = CMD_ROTATE;
    end else begin
      op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    return make_cmd(op, pick_word(), pick_amount());
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle_run > 0) begin
      no_idle_run--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) no_idle_run = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: predicts each accepted transfer, then loads the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_command(cmd_i));
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_i     <= pending_cmds.pop_front();
          start     <= 1'b1;
          idle_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cdq_out_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (res_o.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_o.status);
          error_count++;
        end
        if (res_o.popped_value !== exp_res.popped_value) begin
          $error("popped_value: expected %0d, got %0d",
                 exp_res.popped_value, res_o.popped_value);
          error_count++;
        end
        if (res_o.occupancy !== exp_res.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_res.occupancy, res_o.occupancy);
          error_count++;
        end
        checked_count++;
      end
    end
  end

  initial begin
    int mode;
    int seg_len;
    int n_random;
    pending_cmds.push_back(make_cmd(CMD_POP_FRONT, pick_word(), pick_amount()));
    pending_cmds.push_back(make_cmd(CMD_POP_REAR, pick_word(), pick_amount()));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, pick_word(), 16'h0001));
    for (int op = CMD_UNUSED_FIRST; op <= CMD_UNUSED_LAST; op++) begin
      pending_cmds.push_back(make_cmd(3'(op), $urandom, 16'($urandom)));
    end
    pending_cmds.push_back(make_cmd(CMD_PUSH_REAR, 32'h7fff_ffff, 16'h7fff));
    pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 16'h8000));
    pending_cmds.push_back(make_cmd(CMD_PUSH_REAR, 32'h0, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 32'hffff_ffff, 16'hffff));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'h0, 16'h0004));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'h0, 16'h7fff));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'h0, 16'hffff));
    for (int i = 0; i < int'(DEF_CAPACITY) - 4; i++) begin
      pending_cmds.push_back(make_cmd(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_REAR,
                                      $urandom, 16'($urandom)));
    end
    pending_cmds.push_back(make_cmd(CMD_PUSH_REAR, $urandom, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, $urandom, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'h0, 16'h8000));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'h0, 16'h7fff));
    pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 32'h0, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_POP_REAR, 32'h0, 16'h0));

    // random part: fill, drain and mixed segments
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      mode    = $urandom_range(MODE_FILL, MODE_MIXED);
      seg_len = $urandom_range(10, 50);
      repeat (seg_len) begin
        pending_cmds.push_back(random_cmd(mode));
        n_random++;
      end
    end
    total_items = pending_cmds.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked", accepted_count, checked_count);
    $display("%0d full and %0d empty flags, %0d words moved by rotates",
             full_count, empty_count, moved_words);
    if (error_count == 0) begin
      $display("tb_circular_deque_with_rotate: clean");
    end else begin
      $display("tb_circular_deque_with_rotate: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_circular_deque_with_rotate: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/cdq_pkg.sv
design/cdq_dpath.sv
design/cdq_ctrl.sv
design/circular_deque_with_rotate.sv
verif/tb_circular_deque_with_rotate.sv
